@@ rtl/cas_pkg.sv @@
// Shared types and constants for the cave automaton step unit.
package cas_pkg;

   localparam int CFG_DIM_W  = 11;
   localparam int THR_W      = 4;
   localparam int POS_W      = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;
   localparam int WIN_CELLS  = 9;
   localparam int CNT_W      = 4;

   localparam logic [CFG_DIM_W-1:0] MAP_WIDTH_RESET  = 11'd64;
   localparam logic [CFG_DIM_W-1:0] MAP_HEIGHT_RESET = 11'd64;
   localparam logic [THR_W-1:0]     SURVIVE_RESET    = 4'd4;
   localparam logic [THR_W-1:0]     BIRTH_RESET      = 4'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAP_WIDTH  = 3'd0,
      CSR_MAP_HEIGHT = 3'd1,
      CSR_SURVIVE    = 3'd2,
      CSR_BIRTH      = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic top;
      logic bot;
      logic left;
      logic right;
   } border_type;

endpackage

@@ rtl/cas_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module cas_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/cave_automaton_step_unit.sv @@
// Top level of the cave automaton step unit: line buffer memory, 3x3 window and rule.
// Throughput: one word per clock each way unless rsp stalls; the line buffer RAM is read at
//    acceptance and written back from stage one, so the sustained rate is one cell a cycle.
// Results: a result passes through stage one and the rsp output register after the word that
//    completes its window is accepted; that word trails the result's cell by map_width+1 words.
// Reset (synchronous, active high) restores the registers to 64 x 64 with thresholds 4 and 5,
//    clears the position counters, the window and the pipeline; the RAM is not cleared.
module cave_automaton_step_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   // Cell stream.
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_type,
   input  logic                            req_cell_is_wall,
   // Result stream.
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_new_is_wall,
   output logic [cas_pkg::POS_W-1:0]       rsp_out_row,
   output logic [cas_pkg::POS_W-1:0]       rsp_out_col,
   output logic                            rsp_last_of_frame,
   // Register writes.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cas_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cas_pkg::CSR_DATA_W-1:0]  csr_data
);

   import cas_pkg::*;

   // Column index and RAM address width, width of the clamped map width,
   // and width of the row counter (which runs into the second row past the map while draining).
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = CW + 1;
   localparam int RW = $clog2(MAX_HEIGHT + 2);

   // ---------------------------------------------------------------------
   // Configuration registers. Writes are always taken; a geometry write
   // restarts the frame by clearing the position counters.
   // ---------------------------------------------------------------------
   logic [CFG_DIM_W-1:0] map_width_ff,  map_width_in;
   logic [CFG_DIM_W-1:0] map_height_ff, map_height_in;
   logic [THR_W-1:0]     survive_ff,    survive_in;
   logic [THR_W-1:0]     birth_ff,      birth_in;
   logic                 csr_write;
   logic                 restart;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      survive_in    = survive_ff;
      birth_in      = birth_ff;
      restart       = 1'b0;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_MAP_WIDTH: begin
               map_width_in = csr_data;
               restart      = 1'b1;
            end
            CSR_MAP_HEIGHT: begin
               map_height_in = csr_data;
               restart       = 1'b1;
            end
            CSR_SURVIVE: survive_in = csr_data[THR_W-1:0];
            CSR_BIRTH:   birth_in   = csr_data[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= MAP_WIDTH_RESET;
         map_height_ff <= MAP_HEIGHT_RESET;
         survive_ff    <= SURVIVE_RESET;
         birth_ff      <= BIRTH_RESET;
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
         survive_ff    <= survive_in;
         birth_ff      <= birth_in;
      end
   end

   // Effective geometry: zero is taken as one, anything above the build
   // limit saturates to it.
   logic [31:0]   w_full, h_full;
   logic [WW-1:0] w_eff, w_m1;
   logic [RW-1:0] h_eff, h_m1;

   always_comb begin
      if (map_width_ff == '0) begin
         w_full = 32'd1;
      end else if (32'(map_width_ff) > 32'(MAX_WIDTH)) begin
         w_full = 32'(MAX_WIDTH);
      end else begin
         w_full = 32'(map_width_ff);
      end
      if (map_height_ff == '0) begin
         h_full = 32'd1;
      end else if (32'(map_height_ff) > 32'(MAX_HEIGHT)) begin
         h_full = 32'(MAX_HEIGHT);
      end else begin
         h_full = 32'(map_height_ff);
      end
   end

   assign w_eff = w_full[WW-1:0];
   assign h_eff = h_full[RW-1:0];
   assign w_m1  = w_eff - WW'(1);
   assign h_m1  = h_eff - RW'(1);

   // ---------------------------------------------------------------------
   // Handshake. Stage one holds the word whose RAM data is being read back;
   // it moves on when it makes no result or the output register is free or
   // being emptied in the same cycle. The input is stalled only when stage
   // one is blocked, so a word enters every cycle while results flow.
   // ---------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic s1_res_ff;
   logic s1_go;
   logic req_accept;
   logic rsp_valid_ff, rsp_valid_in;

   assign s1_go      = s1_valid_ff && (!s1_res_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Stage zero: position of the incoming word, the value written into the
   // line buffer and the geometry of the cell whose window it completes.
   // ---------------------------------------------------------------------
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [WW-1:0] col_inc;
   logic          past_map;
   logic          cell_val;
   logic          res_vld;
   logic [RW-1:0] res_row;
   logic [CW-1:0] res_col;
   border_type    res_border;
   logic          res_last;

   assign col_inc = {1'b0, col_ff} + WW'(1);

   always_comb begin
      past_map = row_ff >= h_eff;
      // A drain tick inside the map counts as floor; anything past the map is a drain.
      cell_val = !past_map && !req_type && req_cell_is_wall;

      // The centre cell trails the incoming word by one row and one column.
      if (col_ff != '0) begin
         res_vld = row_ff >= RW'(1);
         res_row = row_ff - RW'(1);
         res_col = col_ff - CW'(1);
      end else begin
         res_vld = row_ff >= RW'(2);
         res_row = row_ff - RW'(2);
         res_col = w_m1[CW-1:0];
      end
      res_vld = res_vld && (res_row < h_eff);

      res_border.top   = res_row == '0;
      res_border.bot   = res_row == h_m1;
      res_border.left  = res_col == '0;
      res_border.right = res_col == w_m1[CW-1:0];
      res_last         = res_vld && res_border.bot && res_border.right;

      row_in = row_ff;
      col_in = col_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (req_accept) begin
         if (res_last) begin
            // The final result of the frame rewinds the counters for the next map.
            row_in = '0;
            col_in = '0;
         end else if (col_inc >= w_eff) begin
            row_in = row_ff + RW'(1);
            col_in = '0;
         end else begin
            col_in = col_inc[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ---------------------------------------------------------------------
   // Line buffer RAM. Each entry holds the current and the previous row's
   // cell for one column: bit 1 is the current row, bit 0 the row above.
   // The word's column is read at acceptance and written back from stage
   // one, shifting current into above and the new cell into current.
   // ---------------------------------------------------------------------
   logic [1:0]    ram_rd_data;
   logic [1:0]    ram_q;
   logic [1:0]    ram_wr_data;
   logic [CW-1:0] s1_addr_ff;
   logic          s1_val_ff;
   logic          s1_fwd_ff, s1_fwd_in;
   logic [1:0]    s1_fwd_data_ff;

   // With a one-column map the next word reads the entry that is being
   // written at the same edge; the write data is forwarded around the RAM.
   assign s1_fwd_in   = s1_go && (s1_addr_ff == col_ff);
   assign ram_q       = s1_fwd_ff ? s1_fwd_data_ff : ram_rd_data;
   assign ram_wr_data = {s1_val_ff, ram_q[1]};

   cas_ram #(
      .WIDTH (2),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // Stage one registers.
   logic [RW-1:0] s1_row_ff;
   logic [CW-1:0] s1_col_ff;
   border_type    s1_border_ff;
   logic          s1_last_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_fwd_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (req_accept) begin
            s1_fwd_ff <= s1_fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_addr_ff     <= col_ff;
         s1_val_ff      <= cell_val;
         s1_res_ff      <= res_vld;
         s1_row_ff      <= res_row;
         s1_col_ff      <= res_col;
         s1_border_ff   <= res_border;
         s1_last_ff     <= res_last;
         s1_fwd_data_ff <= ram_wr_data;
      end
   end

   // ---------------------------------------------------------------------
   // 3x3 window of column vectors. Each column holds, from bit 0, the row
   // above, the centre row and the row below; the oldest column sits in
   // the low bits and shifts out as the new one enters at the top.
   // ---------------------------------------------------------------------
   logic [WIN_CELLS-1:0] win_ff, win_in;
   logic [2:0]           win_col;
   logic [CNT_W-1:0]     nb_count;
   logic                 centre;
   logic                 new_wall;

   assign win_col = {s1_val_ff, ram_q[1], ram_q[0]};
   assign win_in  = {win_col, win_ff[WIN_CELLS-1:3]};

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_go) begin
         win_ff <= win_in;
      end
   end

   // Wall count over the eight neighbours; cells beyond the border count as walls.
   always_comb begin
      logic border;
      nb_count = '0;
      for (int i = 0; i < WIN_CELLS; i++) begin
         border = ((i / 3 == 0) && s1_border_ff.left) || ((i / 3 == 2) && s1_border_ff.right)
               || ((i % 3 == 0) && s1_border_ff.top)  || ((i % 3 == 2) && s1_border_ff.bot);
         if ((i != 4) && (border || win_in[i])) begin
            nb_count = nb_count + CNT_W'(1);
         end
      end
      centre   = win_in[4];
      new_wall = centre ? (nb_count >= survive_ff) : (nb_count >= birth_ff);
   end

   // ---------------------------------------------------------------------
   // Output register.
   // ---------------------------------------------------------------------
   logic                 rsp_load;
   logic                 rsp_wall_ff;
   logic [POS_W-1:0]     rsp_row_ff;
   logic [POS_W-1:0]     rsp_col_ff;
   logic                 rsp_last_ff;
   logic [31:0]          row_full, col_full;

   assign rsp_load = s1_go && s1_res_ff;
   assign row_full = 32'(s1_row_ff);
   assign col_full = 32'(s1_col_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_wall_ff <= new_wall;
         rsp_row_ff  <= row_full[POS_W-1:0];
         rsp_col_ff  <= col_full[POS_W-1:0];
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_is_wall   = rsp_wall_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_last_of_frame = rsp_last_ff;

endmodule

@@ rtl/cas_checker.sv @@
// Port-level checks for the cave automaton step unit and their binding.
module cas_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic                      rsp_new_is_wall,
   input logic [cas_pkg::POS_W-1:0] rsp_out_row,
   input logic [cas_pkg::POS_W-1:0] rsp_out_col,
   input logic                      rsp_last_of_frame
);

   import cas_pkg::*;

   // The input side only backs up behind a blocked result word.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");

   // A new result is raised only from an accepted input word, which passes through stage one
   // into the output register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result appeared without an accepted input word");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_new_is_wall)
         && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_last_of_frame)))
      else $error("stalled result word changed");

endmodule

bind cave_automaton_step_unit cas_checker u_cas_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_new_is_wall   (rsp_new_is_wall),
   .rsp_out_row       (rsp_out_row),
   .rsp_out_col       (rsp_out_col),
   .rsp_last_of_frame (rsp_last_of_frame)
);
